>>> hdl/cbcpad_pkg.sv
// Shared types and constants for the CBC record padding checker.
`default_nettype none

package cbcpad_pkg;

   localparam int TAIL_BYTES         = 256;
   localparam int MAX_FRAGMENT_BYTES = 18432;

   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 15;
   localparam int PHASE_W  = 5;
   localparam int BLK_W    = 6;
   localparam int MAC_W    = 7;
   localparam int PTR_W    = $clog2(TAIL_BYTES);
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [BLK_W-1:0] BLK_MAX   = BLK_W'(32);
   localparam logic [BLK_W-1:0] BLK_MIN   = BLK_W'(1);
   localparam logic [MAC_W-1:0] MAC_RESET = MAC_W'(20);
   localparam logic [BLK_W-1:0] BLK_RESET = BLK_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_MAC_BYTES   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_BAD_LENGTH    = 3'd1,
      ST_BAD_PAD_POS   = 3'd2,
      ST_BAD_PAD_BYTES = 3'd3,
      ST_BAD_MAC_POS   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CHECK,
      FSM_FINISH
   } fsm_type;

endpackage

`default_nettype wire

>>> hdl/cbc_record_padding_check_top.sv
// Top level of the CBC record padding checker: byte intake, tail memory and trailer check.
//
// Bytes of one decrypted fragment enter one per cycle while the block is idle and are written
// into a 256-byte tail memory. After the last byte the block stops taking input while it reads
// the padding bytes back from the tail memory, one read per cycle; it reads nothing when the
// length or padding position already fails. The result then waits in an output register while
// the next fragment's bytes are taken. The block is ready for bytes straight after reset.
`default_nettype none

module cbc_record_padding_check_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [cbcpad_pkg::DATA_W-1:0]      req_data_byte,
   input  wire                                req_last_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [cbcpad_pkg::STATUS_W-1:0]    rsp_check_status,
   output logic [cbcpad_pkg::COUNT_W-1:0]     rsp_content_length,
   output logic [cbcpad_pkg::DATA_W-1:0]      rsp_pad_length,
   input  wire                                csr_wr_en,
   input  wire  [cbcpad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [cbcpad_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = cbcpad_pkg::COUNT_W;
   localparam int PW = cbcpad_pkg::PTR_W;
   localparam int DW = cbcpad_pkg::DATA_W;
   localparam int HW = cbcpad_pkg::PHASE_W;
   localparam int BW = cbcpad_pkg::BLK_W;
   localparam int MW = cbcpad_pkg::MAC_W;
   localparam logic [CW-1:0] MAX_COUNT = CW'(cbcpad_pkg::MAX_FRAGMENT_BYTES);

   // configuration
   logic [MW-1:0] mac_ff;
   logic [BW-1:0] blk_ff;

   // fragment state
   logic [CW-1:0] count_ff, count_in;
   logic [HW-1:0] phase_ff, phase_in;
   logic [PW-1:0] tp_ff, tp_in;
   logic          ovf_ff, ovf_in;

   // check state
   cbcpad_pkg::fsm_type    state_ff, state_in;
   cbcpad_pkg::status_type pre_status_ff, pre_status_in;
   logic [DW-1:0]  pad_ff;
   logic [CW-1:0]  pad_pos_ff;
   logic [PW-1:0]  rd_addr_ff;
   logic [DW-1:0]  remain_ff;
   logic           pending_ff;
   logic           mismatch_ff;
   logic [DW-1:0]  rd_data_ff;

   // output register
   logic                   rsp_valid_ff;
   cbcpad_pkg::status_type rsp_status_ff;
   logic [CW-1:0]          rsp_content_ff;
   logic [DW-1:0]          rsp_pad_ff;

   logic [DW-1:0] tail_mem [cbcpad_pkg::TAIL_BYTES];

   logic          accept;
   logic          accept_last;
   logic          issue;
   logic          load;
   logic [BW-1:0] blk_eff;
   logic [BW-1:0] phase_sum;
   logic          len_bad;
   logic [CW-1:0] n_minus_1;
   logic          pos_bad;
   cbcpad_pkg::status_type fin_status;
   logic [CW-1:0] fin_content;
   logic [CW-1:0] mac_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbcpad_pkg::FSM_IDLE: begin
            if (accept_last) state_in = cbcpad_pkg::FSM_CHECK;
         end
         cbcpad_pkg::FSM_CHECK: begin
            if (remain_ff == '0 && !pending_ff) state_in = cbcpad_pkg::FSM_FINISH;
         end
         cbcpad_pkg::FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = cbcpad_pkg::FSM_IDLE;
         end
         default: state_in = cbcpad_pkg::FSM_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         cbcpad_pkg::FSM_IDLE:   req_stall = 1'b0;
         cbcpad_pkg::FSM_CHECK:  issue = (remain_ff != '0);
         cbcpad_pkg::FSM_FINISH: load = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept      = req_valid && !req_stall;
   assign accept_last = accept && req_last_byte;

   always_comb begin
      priority if (blk_ff == '0)    blk_eff = cbcpad_pkg::BLK_MIN;
      else if (blk_ff > cbcpad_pkg::BLK_MAX) blk_eff = cbcpad_pkg::BLK_MAX;
      else                          blk_eff = blk_ff;
   end

   // advance the running fragment state
   always_comb begin
      phase_sum = {1'b0, phase_ff} + BW'(1);
      phase_in  = (phase_sum >= blk_eff) ? '0 : phase_sum[HW-1:0];
      tp_in     = tp_ff + PW'(1);
      if (count_ff >= MAX_COUNT) begin
         count_in = count_ff;
         ovf_in   = 1'b1;
      end else begin
         count_in = count_ff + CW'(1);
         ovf_in   = ovf_ff;
      end
      len_bad   = ovf_in || (count_in == '0) || (phase_in != '0);
      n_minus_1 = count_in - CW'(1);
      pos_bad   = {{(CW-DW){1'b0}}, req_data_byte} > n_minus_1;
      priority if (len_bad) pre_status_in = cbcpad_pkg::ST_BAD_LENGTH;
      else if (pos_bad)     pre_status_in = cbcpad_pkg::ST_BAD_PAD_POS;
      else                  pre_status_in = cbcpad_pkg::ST_OK;
   end

   // final verdict
   always_comb begin
      mac_ext     = {{(CW-MW){1'b0}}, mac_ff};
      fin_content = '0;
      priority if (pre_status_ff != cbcpad_pkg::ST_OK) begin
         fin_status = pre_status_ff;
      end else if (mismatch_ff) begin
         fin_status = cbcpad_pkg::ST_BAD_PAD_BYTES;
      end else if (mac_ext > pad_pos_ff) begin
         fin_status = cbcpad_pkg::ST_BAD_MAC_POS;
      end else begin
         fin_status  = cbcpad_pkg::ST_OK;
         fin_content = pad_pos_ff - mac_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff       <= cbcpad_pkg::MAC_RESET;
         blk_ff       <= cbcpad_pkg::BLK_RESET;
         count_ff     <= '0;
         phase_ff     <= '0;
         tp_ff        <= '0;
         ovf_ff       <= 1'b0;
         state_ff     <= cbcpad_pkg::FSM_IDLE;
         remain_ff    <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               cbcpad_pkg::CSR_MAC_BYTES:   mac_ff <= csr_wdata[MW-1:0];
               cbcpad_pkg::CSR_BLOCK_BYTES: blk_ff <= csr_wdata[BW-1:0];
               default: ;
            endcase
         end
         state_ff <= state_in;
         if (accept_last) begin
            count_ff  <= '0;
            phase_ff  <= '0;
            tp_ff     <= '0;
            ovf_ff    <= 1'b0;
            remain_ff <= (pre_status_in == cbcpad_pkg::ST_OK) ? req_data_byte : '0;
         end else if (accept) begin
            count_ff <= count_in;
            phase_ff <= phase_in;
            tp_ff    <= tp_in;
            ovf_ff   <= ovf_in;
         end else if (issue) begin
            remain_ff <= remain_ff - DW'(1);
         end
         pending_ff <= issue;
         if (load)            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // check datapath
   always_ff @(posedge clock) begin
      if (accept_last) begin
         pre_status_ff <= pre_status_in;
         pad_ff        <= req_data_byte;
         pad_pos_ff    <= n_minus_1 - {{(CW-DW){1'b0}}, req_data_byte};
         rd_addr_ff    <= tp_ff - PW'(1);
         mismatch_ff   <= 1'b0;
      end else begin
         if (issue) rd_addr_ff <= rd_addr_ff - PW'(1);
         if (pending_ff && rd_data_ff != pad_ff) mismatch_ff <= 1'b1;
      end
      if (load) begin
         rsp_status_ff  <= fin_status;
         rsp_content_ff <= fin_content;
         rsp_pad_ff     <= pad_ff;
      end
   end

   // tail memory: write on intake, read during the check
   always_ff @(posedge clock) begin
      if (accept) tail_mem[tp_ff] <= req_data_byte;
      if (issue)  rd_data_ff <= tail_mem[rd_addr_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_check_status   = rsp_status_ff;
   assign rsp_content_length = rsp_content_ff;
   assign rsp_pad_length     = rsp_pad_ff;

endmodule

`default_nettype wire

>>> hdl/cbcpad_checker.sv
// Port-level assertions for the CBC record padding checker, bound to the top level.
`default_nettype none

module cbcpad_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_stall,
   input wire                                req_last_byte,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire [cbcpad_pkg::STATUS_W-1:0]     rsp_check_status,
   input wire [cbcpad_pkg::COUNT_W-1:0]      rsp_content_length,
   input wire [cbcpad_pkg::DATA_W-1:0]       rsp_pad_length
);

   localparam logic [cbcpad_pkg::COUNT_W:0] MAX_SUM =
      (cbcpad_pkg::COUNT_W+1)'(cbcpad_pkg::MAX_FRAGMENT_BYTES);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_check_status)
         && $stable(rsp_content_length) && $stable(rsp_pad_length))
      else $error("stalled response beat changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_status != cbcpad_pkg::ST_OK |-> rsp_content_length == '0)
      else $error("content length nonzero on error");

   a_ok_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_status == cbcpad_pkg::ST_OK |->
         ({1'b0, rsp_content_length} + (cbcpad_pkg::COUNT_W+1)'(rsp_pad_length)) < MAX_SUM)
      else $error("content plus padding exceeds fragment limit");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> req_stall)
      else $error("input taken during trailer check");

endmodule

bind cbc_record_padding_check_top cbcpad_checker u_cbcpad_checker (.*);

`default_nettype wire

>>> verif/cbc_record_padding_check_top_tb.sv
// Self-checking testbench for the CBC record padding checker: directed fragments, then random ones.
module cbc_record_padding_check_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbcpad_pkg::*;

   localparam int CLK_PERIOD       = 4;
   localparam int RESET_CYCLES     = 10;
   localparam int MAX_GAP          = 18;
   localparam int SETTLE_CYCLES    = 300;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_BEATS     = 450;
   localparam int RANDOM_FRAGS     = 40;
   localparam int N_ROWS           = 19;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] content_len;
      logic [DATA_W-1:0]  pad_len;
   } trailer_t;

   typedef struct packed {
      logic [MAC_W-1:0]      mac;
      logic [CSR_DATA_W-1:0] blk;
      logic [COUNT_W-1:0]    len;
      logic [DATA_W-1:0]     pad;
      logic                  corrupt;
      logic [COUNT_W-1:0]    split;
      logic [CSR_DATA_W-1:0] blk2;
      logic                  typed;
      status_type            status;
      logic [COUNT_W-1:0]    content_len;
   } frag_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_check_status;
   logic [COUNT_W-1:0]    rsp_content_length;
   logic [DATA_W-1:0]     rsp_pad_length;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MAC_BYTES;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block's fragment state and registers
   logic [DATA_W-1:0] tail_mem [TAIL_BYTES];
   int unsigned       frag_len = 0;
   int unsigned       frag_phase = 0;
   logic [PTR_W-1:0]  tail_wr = '0;
   bit                frag_overflow = 1'b0;
   logic [MAC_W-1:0]  cfg_mac = MAC_RESET;
   logic [BLK_W-1:0]  cfg_blk = BLK_RESET;

   trailer_t    expected_trailers [$];
   trailer_t    typed_trailer;
   bit          typed_on = 1'b0;
   bit          long_hold_req = 1'b0;
   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned cycle_count = 0;

   frag_row_t directed_rows [N_ROWS] = '{
      '{7'd20,  7'd16, 15'd32,    8'd3,   1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd8},
      '{7'd20,  7'd16, 15'd16,    8'd15,  1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_MAC_POS,   15'd0},
      '{7'd20,  7'd16, 15'd17,    8'd0,   1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_LENGTH,    15'd0},
      '{7'd0,   7'd1,  15'd1,     8'd0,   1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd0},
      '{7'd0,   7'd1,  15'd1,     8'd1,   1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_PAD_POS,   15'd0},
      '{7'd0,   7'd1,  15'd3,     8'd255, 1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_PAD_POS,   15'd0},
      '{7'd0,   7'd1,  15'd256,   8'd255, 1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd0},
      '{7'd0,   7'd1,  15'd300,   8'd255, 1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd44},
      '{7'd0,   7'd1,  15'd4,     8'd2,   1'b1, 15'd0, 7'd0, 1'b1, ST_BAD_PAD_BYTES, 15'd0},
      '{7'd0,   7'd1,  15'd256,   8'd255, 1'b1, 15'd0, 7'd0, 1'b1, ST_BAD_PAD_BYTES, 15'd0},
      '{7'd64,  7'd32, 15'd96,    8'd31,  1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd0},
      '{7'd64,  7'd32, 15'd64,    8'd0,   1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_MAC_POS,   15'd0},
      '{7'd127, 7'd0,  15'd130,   8'd2,   1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd0},
      '{7'd127, 7'd63, 15'd64,    8'd0,   1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_MAC_POS,   15'd0},
      '{7'd4,   7'd4,  15'd13,    8'd2,   1'b0, 15'd6, 7'd3, 1'b0, ST_OK,            15'd0},
      '{7'd3,   7'd5,  15'd20,    8'd4,   1'b0, 15'd0, 7'd0, 1'b0, ST_OK,            15'd0},
      '{7'd20,  7'd16, 15'd18432, 8'd7,   1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd18404},
      '{7'd20,  7'd16, 15'd18448, 8'd7,   1'b0, 15'd0, 7'd0, 1'b1, ST_BAD_LENGTH,    15'd0},
      '{7'd0,   7'd1,  15'd2,     8'd0,   1'b0, 15'd0, 7'd0, 1'b1, ST_OK,            15'd1}
   };

   cbc_record_padding_check_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_check_status   (rsp_check_status),
      .rsp_content_length (rsp_content_length),
      .rsp_pad_length     (rsp_pad_length),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned eff_block(input logic [BLK_W-1:0] blk);
      if (blk == 0) return 1;
      if (blk > BLK_MAX) return BLK_MAX;
      return blk;
   endfunction

   // advance the fragment shadow by one byte; returns 1 with the trailer verdict on a last byte
   function automatic bit absorb_byte(input logic [DATA_W-1:0] d, input logic last,
                                      output trailer_t t);
      int unsigned      blk, n, p, i, pad_pos;
      logic [PTR_W-1:0] rd;
      status_type       st;
      blk = eff_block(cfg_blk);
      t = '0;
      if (frag_len >= MAX_FRAGMENT_BYTES) frag_overflow = 1'b1;
      else frag_len = frag_len + 1;
      frag_phase = (frag_phase + 1 >= blk) ? 0 : frag_phase + 1;
      tail_mem[tail_wr] = d;
      tail_wr = tail_wr + PTR_W'(1);
      if (!last) return 1'b0;
      n = frag_len;
      p = d;
      st = ST_OK;
      if (frag_overflow || n == 0 || frag_phase != 0) begin
         st = ST_BAD_LENGTH;
      end else if (p > n - 1) begin
         st = ST_BAD_PAD_POS;
      end else begin
         for (i = 0; i <= p && st == ST_OK; i = i + 1) begin
            rd = tail_wr - PTR_W'(1) - PTR_W'(i);
            if (tail_mem[rd] != d) st = ST_BAD_PAD_BYTES;
         end
         if (st == ST_OK) begin
            pad_pos = n - 1 - p;
            if (cfg_mac > pad_pos) st = ST_BAD_MAC_POS;
            else t.content_len = COUNT_W'(pad_pos - cfg_mac);
         end
      end
      t.status = st;
      t.pad_len = d;
      frag_len = 0;
      frag_phase = 0;
      tail_wr = '0;
      frag_overflow = 1'b0;
      return 1'b1;
   endfunction

   task automatic drop_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_beat(input logic [DATA_W-1:0] d, input logic last, input int gap);
      trailer_t t;
      if (gap > 0) begin
         drop_req();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      beats_sent = beats_sent + 1;
      if (absorb_byte(d, last, t)) begin
         if (typed_on) expected_trailers.push_back(typed_trailer);
         else expected_trailers.push_back(t);
      end
   endtask

   task automatic wait_idle();
      drop_req();
      while (expected_trailers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAC_BYTES) cfg_mac = val[MAC_W-1:0];
      else cfg_blk = val[BLK_W-1:0];
   endtask

   task automatic send_fragment(input int len, input int pad, input bit fill, input bit corrupt,
                                input bit burst, input int split,
                                input logic [CSR_DATA_W-1:0] blk2);
      int                i, bad_at;
      logic [DATA_W-1:0] d;
      bad_at = -1;
      if (corrupt && pad > 0) bad_at = len - 1 - int'($urandom_range(1, pad));
      for (i = 0; i < len; i = i + 1) begin
         if (split > 0 && i == split) begin
            wait_idle();
            write_reg(CSR_BLOCK_BYTES, blk2);
         end
         d = $urandom_range(0, 255);
         if (fill && i >= len - 1 - pad) d = pad[DATA_W-1:0];
         if (i == bad_at) d = ~pad[DATA_W-1:0];
         if (i == len - 1) d = pad[DATA_W-1:0];
         send_beat(d, i == len - 1, burst ? 0 : int'($urandom_range(0, MAX_GAP)));
      end
   endtask

   initial begin : stimulus
      int                    r, e, k, len, p, kind, frags, rand_start, n_in_phase;
      bit                    fill, corrupt, burst;
      frag_row_t             row;
      logic [CSR_DATA_W-1:0] wval;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r = r + 1) begin
         row = directed_rows[r];
         if (row.mac != cfg_mac || row.blk[BLK_W-1:0] != cfg_blk) begin
            wait_idle();
            if (row.mac != cfg_mac) write_reg(CSR_MAC_BYTES, CSR_DATA_W'(row.mac));
            if (row.blk[BLK_W-1:0] != cfg_blk) write_reg(CSR_BLOCK_BYTES, row.blk);
         end
         typed_on = row.typed;
         typed_trailer = '{row.status, row.content_len, row.pad};
         burst = (row.len > 1000) || ($urandom_range(0, 2) == 0);
         send_fragment(row.len, row.pad, 1'b1, row.corrupt, burst, row.split, row.blk2);
         typed_on = 1'b0;
      end

      rand_start = beats_sent;
      frags = 0;
      while (beats_sent - rand_start < RANDOM_BEATS || frags < RANDOM_FRAGS) begin
         wait_idle();
         case ($urandom_range(0, 4))
            0:       wval = 7'd0;
            1:       wval = 7'd64;
            2:       wval = 7'd127;
            3:       wval = $urandom_range(0, 127);
            default: wval = $urandom_range(0, 24);
         endcase
         write_reg(CSR_MAC_BYTES, wval);
         case ($urandom_range(0, 5))
            0:       wval = 7'd0;
            1:       wval = 7'd1;
            2:       wval = 7'd32;
            3:       wval = 7'd63;
            4:       wval = $urandom_range(0, 63);
            default: wval = $urandom_range(1, 8);
         endcase
         wval[CSR_DATA_W-1] = $urandom_range(0, 1);
         write_reg(CSR_BLOCK_BYTES, wval);
         if (frags == 0) long_hold_req = 1'b1;
         n_in_phase = $urandom_range(4, 8);
         repeat (n_in_phase) begin
            e = eff_block(cfg_blk);
            k = $urandom_range(1, (e > 24) ? 1 : 24 / e);
            len = e * k;
            p = $urandom_range(0, (len - 1 > 255) ? 255 : len - 1);
            fill = 1'b1;
            corrupt = 1'b0;
            kind = $urandom_range(0, 9);
            case (kind)
               6: corrupt = 1'b1;
               7: begin
                  len = $urandom_range(1, 40);
                  p = $urandom_range(0, 255);
                  fill = 1'b0;
               end
               8: if (len <= 255) p = $urandom_range(len, 255);
               9: if (e > 1) len = len + int'($urandom_range(1, e - 1));
               default: if ($urandom_range(0, 15) == 0) begin
                  p = $urandom_range(128, 255);
                  len = ((p + 1 + int'($urandom_range(0, 40)) + e - 1) / e) * e;
               end
            endcase
            burst = ($urandom_range(0, 3) == 0);
            send_fragment(len, p, fill, corrupt, burst, 0, '0);
            frags = frags + 1;
         end
      end

      wait_idle();
      if (mismatches == 0 && expected_trailers.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin : result_sink
      int       w, calm;
      trailer_t want;
      calm = 0;
      wait (reset === 1'b0);
      forever begin
         if (long_hold_req) begin
            w = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end else if (calm > 0) begin
            w = 0;
            calm = calm - 1;
         end else begin
            w = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0) calm = 12;
         end
         if (w > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (w - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_trailers.size() == 0) begin
            mismatches = mismatches + 1;
            $display("%0t: unexpected beat: status %0d content_length %0d pad_length %0d",
                     $time, rsp_check_status, rsp_content_length, rsp_pad_length);
         end else begin
            want = expected_trailers.pop_front();
            if (rsp_check_status !== want.status) begin
               mismatches = mismatches + 1;
               $display("%0t: check_status expected %0d actual %0d",
                        $time, want.status, rsp_check_status);
            end
            if (rsp_content_length !== want.content_len) begin
               mismatches = mismatches + 1;
               $display("%0t: content_length expected %0d actual %0d",
                        $time, want.content_len, rsp_content_length);
            end
            if (rsp_pad_length !== want.pad_len) begin
               mismatches = mismatches + 1;
               $display("%0t: pad_length expected %0d actual %0d",
                        $time, want.pad_len, rsp_pad_length);
            end
         end
      end
   end

endmodule

>>> cbc_record_padding_check_top.f
hdl/cbcpad_pkg.sv
hdl/cbc_record_padding_check_top.sv
hdl/cbcpad_checker.sv
verif/cbc_record_padding_check_top_tb.sv
